@@ design/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define RHC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define RHC_ASSERT_IMPL(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("implication failed");
`define RHC_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("next-cycle implication failed");
`else
`define RHC_ASSERT(lbl, clk, rst_n, prop)
`define RHC_ASSERT_IMPL(lbl, clk, rst_n, pre, post)
`define RHC_ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif

`endif

@@ design/rhc_pkg.sv @@
`default_nettype none

package rhc_pkg;

  typedef logic [1:0] mode_t;
  typedef logic [7:0] byte_t;

  localparam mode_t MODE_NAME  = 2'd0;
  localparam mode_t MODE_VALUE = 2'd1;
  localparam mode_t MODE_END   = 2'd2;

  localparam byte_t CH_COLON = 8'h3A;
  localparam byte_t CH_CR    = 8'h0D;
  localparam byte_t CH_LF    = 8'h0A;
  localparam byte_t CH_SPACE = 8'h20;

  function automatic logic is_ws(input byte_t b);
    return (b == CH_SPACE) || ((b >= 8'h09) && (b <= 8'h0D));
  endfunction

  function automatic byte_t to_lower(input byte_t b);
    if ((b >= 8'h41) && (b <= 8'h5A)) begin
      return b + 8'h20;
    end
    return b;
  endfunction

endpackage

`default_nettype wire

@@ design/relaxed_header_canonicalizer_core.sv @@
`default_nettype none
// Relaxed header canonicaliser: takes one header as name words, value words and an end
// word, and emits the canonical line "name:value" CR LF, one byte per output word, with
// out_last_of_header high on the final LF. Each input word is processed in the cycle it
// is accepted and its zero to three output bytes are loaded into a three-slot output
// buffer that drains one byte per cycle while out_ready is high. A word yielding at most
// one byte is taken every cycle under a ready sink; a word yielding more holds off the
// next word until the buffer is down to its last byte and the sink is taking it.

`include "assert_macros.svh"

module relaxed_header_canonicalizer_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire rhc_pkg::mode_t     in_mode,
  input  wire rhc_pkg::byte_t     in_byte,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output rhc_pkg::byte_t          out_byte,
  output logic                    out_last_of_header
);

  logic           colon_sent_r, colon_sent_nxt;
  logic           value_started_r, value_started_nxt;
  logic           space_pending_r, space_pending_nxt;
  logic [1:0]     cnt_r, cnt_nxt;
  logic           last_r, last_nxt;
  rhc_pkg::byte_t slot_r [3];
  rhc_pkg::byte_t slot_nxt [3];

  logic           in_fire;
  logic           out_fire;
  logic [1:0]     new_cnt;
  logic           new_last;
  rhc_pkg::byte_t new_slot [3];

  assign out_valid          = (cnt_r != 2'd0);
  assign out_byte           = slot_r[0];
  assign out_last_of_header = last_r && (cnt_r == 2'd1);
  assign out_fire           = out_valid && out_ready;
  assign in_ready           = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ready);
  assign in_fire            = in_valid && in_ready;

  // byte generation for one input word
  always_comb begin
    logic [1:0] k;
    k                 = 2'd0;
    new_cnt           = 2'd0;
    new_last          = 1'b0;
    new_slot[0]       = rhc_pkg::CH_COLON;
    new_slot[1]       = rhc_pkg::CH_CR;
    new_slot[2]       = rhc_pkg::CH_LF;
    colon_sent_nxt    = colon_sent_r;
    value_started_nxt = value_started_r;
    space_pending_nxt = space_pending_r;
    case (in_mode)
      rhc_pkg::MODE_NAME: begin
        new_slot[0] = rhc_pkg::to_lower(in_byte);
        new_cnt     = 2'd1;
      end
      rhc_pkg::MODE_VALUE: begin
        if (rhc_pkg::is_ws(in_byte)) begin
          if (value_started_r) begin
            space_pending_nxt = 1'b1;
          end
        end else begin
          if (!colon_sent_r) begin
            new_slot[k] = rhc_pkg::CH_COLON;
            k           = k + 2'd1;
          end
          if (space_pending_r) begin
            new_slot[k] = rhc_pkg::CH_SPACE;
            k           = k + 2'd1;
          end
          new_slot[k]       = in_byte;
          new_cnt           = k + 2'd1;
          colon_sent_nxt    = 1'b1;
          value_started_nxt = 1'b1;
          space_pending_nxt = 1'b0;
        end
      end
      rhc_pkg::MODE_END: begin
        if (colon_sent_r) begin
          new_slot[0] = rhc_pkg::CH_CR;
          new_slot[1] = rhc_pkg::CH_LF;
          new_cnt     = 2'd2;
        end else begin
          new_cnt     = 2'd3;
        end
        new_last          = 1'b1;
        colon_sent_nxt    = 1'b0;
        value_started_nxt = 1'b0;
        space_pending_nxt = 1'b0;
      end
      default: begin
        new_cnt = 2'd0;
      end
    endcase
  end

  // output buffer
  always_comb begin
    cnt_nxt     = cnt_r;
    last_nxt    = last_r;
    slot_nxt[0] = slot_r[0];
    slot_nxt[1] = slot_r[1];
    slot_nxt[2] = slot_r[2];
    if (in_fire) begin
      cnt_nxt     = new_cnt;
      last_nxt    = new_last;
      slot_nxt[0] = new_slot[0];
      slot_nxt[1] = new_slot[1];
      slot_nxt[2] = new_slot[2];
    end else if (out_fire) begin
      cnt_nxt     = cnt_r - 2'd1;
      slot_nxt[0] = slot_r[1];
      slot_nxt[1] = slot_r[2];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      colon_sent_r    <= 1'b0;
      value_started_r <= 1'b0;
      space_pending_r <= 1'b0;
      cnt_r           <= 2'd0;
      last_r          <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      last_r <= last_nxt;
      if (in_fire) begin
        colon_sent_r    <= colon_sent_nxt;
        value_started_r <= value_started_nxt;
        space_pending_r <= space_pending_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    slot_r[0] <= slot_nxt[0];
    slot_r[1] <= slot_nxt[1];
    slot_r[2] <= slot_nxt[2];
  end

  `RHC_ASSERT_IMPL(a_last_is_lf, clk, rst_n, out_valid && out_last_of_header,
                   out_byte == rhc_pkg::CH_LF)
  `RHC_ASSERT_IMPL(a_pending_needs_value, clk, rst_n, space_pending_r, value_started_r)
  `RHC_ASSERT_NEXT(a_end_clears, clk, rst_n, in_fire && (in_mode == rhc_pkg::MODE_END),
                   !colon_sent_r && !value_started_r && !space_pending_r)
  `RHC_ASSERT_IMPL(a_accept_only_when_drained, clk, rst_n, in_fire,
                   (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_fire))

endmodule

`default_nettype wire

@@ sim/tb_top.sv @@
`default_nettype none

module tb_top;

  localparam rhc_pkg::mode_t MODE_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int WORD_TARGET = 330;

  typedef struct packed {
    rhc_pkg::byte_t data;
    logic           last;
  } canon_rec_t;

  logic           clk = 1'b0;
  logic           rst_n = 1'b0;
  logic           in_valid = 1'b0;
  logic           in_ready;
  rhc_pkg::mode_t in_mode = rhc_pkg::MODE_NAME;
  rhc_pkg::byte_t in_byte = 8'h00;
  logic           out_valid;
  logic           out_ready = 1'b0;
  rhc_pkg::byte_t out_byte;
  logic           out_last_of_header;

  canon_rec_t canon_q[$];
  logic colon_out = 1'b0;
  logic value_seen = 1'b0;
  logic space_owed = 1'b0;
  int   mismatches = 0;
  int   words_sent = 0;
  int   cycles = 0;
  int   rx_stall = 0;
  bit   calm = 1'b0;

  relaxed_header_canonicalizer_core dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_mode            (in_mode),
    .in_byte            (in_byte),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_byte           (out_byte),
    .out_last_of_header (out_last_of_header)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 30);
  endfunction

  function automatic void push_canon(input rhc_pkg::byte_t data, input logic last);
    canon_rec_t rec;
    rec.data = data;
    rec.last = last;
    canon_q.push_back(rec);
  endfunction

  // expected canonical bytes for one accepted word
  function automatic void canonicalise_word(input rhc_pkg::mode_t m, input rhc_pkg::byte_t b);
    logic blank;
    blank = (b == rhc_pkg::CH_SPACE) || (b >= 8'h09 && b <= 8'h0D);
    case (m)
      rhc_pkg::MODE_NAME: begin
        push_canon((b >= 8'h41 && b <= 8'h5A) ? b + 8'h20 : b, 1'b0);
      end
      rhc_pkg::MODE_VALUE: begin
        if (blank) begin
          if (value_seen) begin
            space_owed = 1'b1;
          end
        end else begin
          if (!colon_out) begin
            push_canon(rhc_pkg::CH_COLON, 1'b0);
            colon_out = 1'b1;
          end
          if (space_owed) begin
            push_canon(rhc_pkg::CH_SPACE, 1'b0);
          end
          push_canon(b, 1'b0);
          value_seen = 1'b1;
          space_owed = 1'b0;
        end
      end
      rhc_pkg::MODE_END: begin
        if (!colon_out) begin
          push_canon(rhc_pkg::CH_COLON, 1'b0);
        end
        push_canon(rhc_pkg::CH_CR, 1'b0);
        push_canon(rhc_pkg::CH_LF, 1'b1);
        colon_out = 1'b0;
        value_seen = 1'b0;
        space_owed = 1'b0;
      end
      default: begin
      end
    endcase
  endfunction

  always @(posedge clk) begin : monitor
    canon_rec_t want;
    cycles <= cycles + 1;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        canonicalise_word(in_mode, in_byte);
      end
      if (out_valid && out_ready) begin
        if (canon_q.size() == 0) begin
          $error("out_byte: expected none, actual %02h", out_byte);
          mismatches++;
        end else begin
          want = canon_q.pop_front();
          if (out_byte !== want.data) begin
            $error("out_byte: expected %02h, actual %02h", want.data, out_byte);
            mismatches++;
          end
          if (out_last_of_header !== want.last) begin
            $error("last_of_header: expected %0b, actual %0b", want.last,
                   out_last_of_header);
            mismatches++;
          end
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  // sink side back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (rx_stall > 0) begin
      rx_stall <= rx_stall - 1;
      out_ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      rx_stall <= pick_gap();
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic send_word(input rhc_pkg::mode_t m, input rhc_pkg::byte_t b);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_mode <= m;
    in_byte <= b;
    do @(posedge clk); while (!in_ready);
    if (m != MODE_UNUSED) begin
      words_sent++;
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (canon_q.size() != 0);
  endtask

  function automatic rhc_pkg::byte_t name_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      return 8'h41 + rhc_pkg::byte_t'($urandom_range(0, 25));
    end else if (r < 70) begin
      return 8'h61 + rhc_pkg::byte_t'($urandom_range(0, 25));
    end
    return rhc_pkg::byte_t'($urandom_range(0, 255));
  endfunction

  function automatic rhc_pkg::byte_t value_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 20) begin
      return rhc_pkg::CH_SPACE;
    end else if (r < 35) begin
      return 8'h09 + rhc_pkg::byte_t'($urandom_range(0, 4));
    end else if (r < 40) begin
      return ($urandom_range(0, 1) == 0) ? 8'h08 : 8'h0E;
    end else if (r < 75) begin
      return 8'h21 + rhc_pkg::byte_t'($urandom_range(0, 93));
    end
    return rhc_pkg::byte_t'($urandom_range(0, 255));
  endfunction

  task automatic send_random_header();
    int name_len;
    int val_len;
    int r;
    name_len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
    val_len = $urandom_range(0, 10);
    repeat (name_len) send_word(rhc_pkg::MODE_NAME, name_char());
    repeat (val_len) begin
      r = $urandom_range(0, 99);
      if (r < 3) begin
        send_word(rhc_pkg::MODE_NAME, name_char());
      end else if (r < 6) begin
        send_word(MODE_UNUSED, rhc_pkg::byte_t'($urandom_range(0, 255)));
      end else begin
        send_word(rhc_pkg::MODE_VALUE, value_char());
      end
    end
    send_word(rhc_pkg::MODE_END, rhc_pkg::byte_t'($urandom_range(0, 255)));
  endtask

  task automatic test_directed();
    // case folding edges and odd bytes in the name
    send_word(rhc_pkg::MODE_NAME, 8'h41);
    send_word(rhc_pkg::MODE_NAME, 8'h5A);
    send_word(rhc_pkg::MODE_NAME, 8'h40);
    send_word(rhc_pkg::MODE_NAME, 8'h5B);
    send_word(rhc_pkg::MODE_NAME, 8'h00);
    send_word(rhc_pkg::MODE_NAME, 8'hFF);
    // leading, inner and trailing whitespace
    send_word(rhc_pkg::MODE_VALUE, 8'h20);
    send_word(rhc_pkg::MODE_VALUE, 8'h09);
    send_word(rhc_pkg::MODE_VALUE, 8'h58);
    send_word(rhc_pkg::MODE_VALUE, 8'h0D);
    send_word(rhc_pkg::MODE_VALUE, 8'h0B);
    send_word(MODE_UNUSED, 8'h41);
    send_word(rhc_pkg::MODE_VALUE, 8'h08);
    send_word(rhc_pkg::MODE_VALUE, 8'h80);
    send_word(rhc_pkg::MODE_VALUE, 8'h20);
    send_word(rhc_pkg::MODE_END, 8'hFF);
    // empty name and empty value
    send_word(rhc_pkg::MODE_END, 8'h00);
    // whitespace-only value
    send_word(rhc_pkg::MODE_VALUE, 8'h0C);
    send_word(rhc_pkg::MODE_END, 8'h3A);
    // name word after the colon
    send_word(rhc_pkg::MODE_VALUE, 8'h61);
    send_word(rhc_pkg::MODE_NAME, 8'h4D);
    send_word(rhc_pkg::MODE_VALUE, 8'h0E);
    send_word(rhc_pkg::MODE_END, 8'h00);
  endtask

  task automatic test_random_headers(input int upto);
    while (words_sent < upto) send_random_header();
  endtask

  task automatic test_sender_pause();
    send_word(rhc_pkg::MODE_NAME, name_char());
    send_word(rhc_pkg::MODE_VALUE, value_char());
    wait_drained();
    send_random_header();
    send_random_header();
    wait_drained();
    send_random_header();
  endtask

  task automatic test_back_to_back();
    calm = 1'b1;
    test_random_headers(words_sent + 40);
    calm = 1'b0;
  endtask

  task automatic test_noise();
    repeat (40) send_word(rhc_pkg::mode_t'($urandom_range(0, 3)),
                          rhc_pkg::byte_t'($urandom_range(0, 255)));
    send_word(rhc_pkg::MODE_END, 8'h00);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_headers(150);
    test_sender_pause();
    test_back_to_back();
    test_noise();
    test_random_headers(WORD_TARGET);
    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && canon_q.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ relaxed_header_canonicalizer_core.f @@
+incdir+design
design/rhc_pkg.sv
design/relaxed_header_canonicalizer_core.sv
sim/tb_top.sv
